// ===== hw/rtl/ptpb_pkg.sv =====
package ptpb_pkg;

  // Field widths
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PortW  = 16;
  localparam int unsigned SeqW   = 32;
  localparam int unsigned FlagsW = 8;
  localparam int unsigned IdentW = 16;
  localparam int unsigned TtlW   = 8;
  localparam int unsigned WinW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned InDataW  = 152;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDX_TTL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_WIN = 2'd1;

  // Configuration reset values
  localparam logic [TtlW-1:0] TTL_RESET = 8'd64;
  localparam logic [WinW-1:0] WIN_RESET = 16'd4096;

  // Header constants
  localparam int unsigned       HdrWords      = 10;
  localparam logic [IdxW-1:0]   WORD_IDX_LAST = 4'd9;
  localparam logic [7:0]        PROTO_TCP     = 8'h06;
  localparam logic [15:0]       IP_VER_IHL_TOS = 16'h4500;
  localparam logic [15:0]       IP_TOTAL_LEN  = 16'd40;
  localparam logic [15:0]       TCP_LEN       = 16'd20;
  localparam logic [7:0]        TCP_DOFF      = 8'h50;

  // One header request with its configured fields and checksums
  typedef struct packed {
    logic [AddrW-1:0]  src_addr;
    logic [AddrW-1:0]  dst_addr;
    logic [PortW-1:0]  src_port;
    logic [PortW-1:0]  dst_port;
    logic [SeqW-1:0]   seq_number;
    logic [FlagsW-1:0] tcp_flags;
    logic [IdentW-1:0] ip_ident;
    logic [TtlW-1:0]   ttl;
    logic [WinW-1:0]   window;
    logic [15:0]       ip_csum;
    logic [15:0]       tcp_csum;
  } hdr_item_t;

endpackage

// ===== hw/rtl/ipv4_tcp_probe_packet_builder_core.sv =====
// IPv4 + TCP probe header builder.
// Input stream (in_*): one beat per probe; in_tdata carries the request
// fields. Output stream (out_*): ten 32-bit header words per probe in
// wire order, out_tuser giving the word position and out_tlast marking
// word nine. Configuration port (cfg_*): index 0 sets the TTL, index 1
// the TCP window; write only while no probe is in flight.
// A probe's first word is presented once the probe has passed the three
// checksum stages, the first loaded at the edge that takes it, and then
// the word register stage.
// The single 32-bit output channel sets the probe rate; words of
// consecutive probes follow with no gap, and the checksum stages take new
// probes while the serializer is still sending.
// Reset (synchronous, active low) empties the pipeline, drops any header
// in progress and restores TTL 64 and window 4096.
// When the receiver stalls, the current word holds and the checksum stages
// fill and then hold in_tready low; nothing is lost or repeated.
module ipv4_tcp_probe_packet_builder_core
  import ptpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // Fields from bit 0: src_addr, dst_addr, src_port, dst_port,
  // seq_number, tcp_flags, ip_ident
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  // Fields from bit 0: header_word
  output logic [WordW-1:0]    out_tdata,
  // Fields from bit 0: word_index
  output logic [IdxW-1:0]     out_tuser,
  output logic                out_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  logic [TtlW-1:0] ttl_r;
  logic [WinW-1:0] window_r;
  logic            pipe_valid, pipe_ready;
  hdr_item_t       pipe_item;

  // Configuration registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r    <= TTL_RESET;
      window_r <= WIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_TTL: ttl_r    <= cfg_data[TtlW-1:0];
        CFG_IDX_WIN: window_r <= cfg_data[WinW-1:0];
        default: ;
      endcase
    end
  end

  ptpb_csum_pipe u_csum_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .ttl       (ttl_r),
    .window    (window_r),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_item  (pipe_item)
  );

  ptpb_serializer u_serializer (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (pipe_valid),
    .in_ready   (pipe_ready),
    .in_item    (pipe_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== hw/rtl/ptpb_csum_pipe.sv =====
module ptpb_csum_pipe
  import ptpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [InDataW-1:0]  in_data,
  input  logic [TtlW-1:0]     ttl,
  input  logic [WinW-1:0]     window,
  output logic                out_valid,
  input  logic                out_ready,
  output hdr_item_t           out_item
);

  // Stage 1: unpacked item and partial sums
  hdr_item_t   s1_item_r;
  logic        s1_vld_r;
  logic [17:0] s1_addr_sum_r, s1_ip_misc_r, s1_tcp_misc_r, s1_tcp_w8_r;
  // Stage 2: full sums
  hdr_item_t   s2_item_r;
  logic        s2_vld_r;
  logic [18:0] s2_ip_sum_r;
  logic [19:0] s2_tcp_sum_r;
  // Stage 3: folded checksums
  hdr_item_t   s3_item_r, s3_item_nxt;
  logic        s3_vld_r;

  logic        s1_adv, s2_adv, s3_adv;
  hdr_item_t   in_item;

  function automatic logic [15:0] fold_csum(input logic [19:0] s);
    logic [16:0] s1;
    logic [15:0] s2;
    s1 = {13'd0, s[19:16]} + {1'b0, s[15:0]};
    s2 = s1[15:0] + {15'd0, s1[16]};
    return ~s2;
  endfunction

  // Stall handling: a stage moves when it is empty or the next one moves
  assign s3_adv   = !s3_vld_r || out_ready;
  assign s2_adv   = !s2_vld_r || s3_adv;
  assign s1_adv   = !s1_vld_r || s2_adv;
  assign in_ready = s1_adv;

  // Unpack the input beat
  always_comb begin
    in_item            = '0;
    in_item.src_addr   = in_data[31:0];
    in_item.dst_addr   = in_data[63:32];
    in_item.src_port   = in_data[79:64];
    in_item.dst_port   = in_data[95:80];
    in_item.seq_number = in_data[127:96];
    in_item.tcp_flags  = in_data[135:128];
    in_item.ip_ident   = in_data[151:136];
    in_item.ttl        = ttl;
    in_item.window     = window;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_valid;
      if (s2_adv) s2_vld_r <= s1_vld_r;
      if (s3_adv) s3_vld_r <= s2_vld_r;
    end
  end

  // Stage 1: partial sums, each of four 16-bit terms
  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_item_r     <= in_item;
      s1_addr_sum_r <= {2'd0, in_item.src_addr[31:16]} + {2'd0, in_item.src_addr[15:0]}
                     + {2'd0, in_item.dst_addr[31:16]} + {2'd0, in_item.dst_addr[15:0]};
      s1_ip_misc_r  <= {2'd0, in_item.ip_ident} + {2'd0, in_item.ttl, PROTO_TCP}
                     + {2'd0, IP_VER_IHL_TOS} + {2'd0, IP_TOTAL_LEN};
      s1_tcp_misc_r <= {2'd0, in_item.src_port} + {2'd0, in_item.dst_port}
                     + {2'd0, in_item.seq_number[31:16]} + {2'd0, in_item.seq_number[15:0]};
      s1_tcp_w8_r   <= {2'd0, TCP_DOFF, in_item.tcp_flags} + {2'd0, in_item.window}
                     + {10'd0, PROTO_TCP} + {2'd0, TCP_LEN};
    end
  end

  // Stage 2: combine into the two checksum sums
  always_ff @(posedge clk) begin
    if (s2_adv && s1_vld_r) begin
      s2_item_r    <= s1_item_r;
      s2_ip_sum_r  <= {1'b0, s1_addr_sum_r} + {1'b0, s1_ip_misc_r};
      s2_tcp_sum_r <= {2'd0, s1_addr_sum_r} + {2'd0, s1_tcp_misc_r} + {2'd0, s1_tcp_w8_r};
    end
  end

  // Stage 3: fold carries and complement
  always_comb begin
    s3_item_nxt          = s2_item_r;
    s3_item_nxt.ip_csum  = fold_csum({1'b0, s2_ip_sum_r});
    s3_item_nxt.tcp_csum = fold_csum(s2_tcp_sum_r);
  end

  always_ff @(posedge clk) begin
    if (s3_adv && s2_vld_r) begin
      s3_item_r <= s3_item_nxt;
    end
  end

  assign out_valid = s3_vld_r;
  assign out_item  = s3_item_r;

endmodule

// ===== hw/rtl/ptpb_serializer.sv =====
module ptpb_serializer
  import ptpb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hdr_item_t         in_item,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WordW-1:0]  out_tdata,
  output logic [IdxW-1:0]   out_tuser,
  output logic              out_tlast
);

  hdr_item_t             hdr_r;
  logic                  busy_r, busy_nxt;
  logic [IdxW-1:0]       cnt_r, cnt_nxt;
  logic [WordW-1:0]      words [HdrWords];
  logic                  last_beat;

  assign last_beat = busy_r && out_tready && (cnt_r == WORD_IDX_LAST);
  assign in_ready  = !busy_r || last_beat;

  // Lay out the header in wire order
  always_comb begin
    words[0] = {IP_VER_IHL_TOS, IP_TOTAL_LEN};
    words[1] = {hdr_r.ip_ident, 16'd0};
    words[2] = {hdr_r.ttl, PROTO_TCP, hdr_r.ip_csum};
    words[3] = hdr_r.src_addr;
    words[4] = hdr_r.dst_addr;
    words[5] = {hdr_r.src_port, hdr_r.dst_port};
    words[6] = hdr_r.seq_number;
    words[7] = '0;
    words[8] = {TCP_DOFF, hdr_r.tcp_flags, hdr_r.window};
    words[9] = {hdr_r.tcp_csum, 16'd0};
  end

  // Word counter and busy flag
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (in_valid && in_ready) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (last_beat) begin
      busy_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (busy_r && out_tready) begin
      cnt_nxt  = cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Hold the item being sent
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hdr_r <= in_item;
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = words[cnt_r];
  assign out_tuser  = cnt_r;
  assign out_tlast  = (cnt_r == WORD_IDX_LAST);

  // Counter never passes the last word
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= WORD_IDX_LAST)
    else $error("word counter out of range");

  // A stalled beat keeps its position in the header
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !out_tready |=> busy_r && $stable(cnt_r))
    else $error("word position moved during stall");

  // A new header always starts at word zero
  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> busy_r && cnt_r == '0)
    else $error("header did not start at word zero");

  // Last word with nothing queued leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    last_beat && !in_valid |=> !busy_r)
    else $error("output still valid after final word");

endmodule
